// ===== rtl/core/gmb_pkg.sv =====
// ----------------------------------------------------------------------------
// gmb_pkg
// shared types and codes of the grid maze path search block
// ----------------------------------------------------------------------------
package gmb_pkg;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_SOLVE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [2:0] CFG_NUM_ROWS  = 3'd0;
    localparam logic [2:0] CFG_NUM_COLS  = 3'd1;
    localparam logic [2:0] CFG_START_ROW = 3'd2;
    localparam logic [2:0] CFG_START_COL = 3'd3;
    localparam logic [2:0] CFG_END_ROW   = 3'd4;
    localparam logic [2:0] CFG_END_COL   = 3'd5;

    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    localparam logic [11:0] LEN_MAX = 12'hFFF;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic       blocked;
    } gmb_in_t;

    typedef struct packed {
        logic        found;
        logic [11:0] path_length;
        logic        move_valid;
        logic [1:0]  move;
        logic        last_move;
    } gmb_out_t;

    typedef struct packed {
        logic load;
        logic read;
        logic clr;
        logic init;
        logic fail;
        logic deq;
        logic cur;
        logic nb_read;
        logic nb_take;
        logic dir_next;
        logic tr_begin;
        logic tr_read;
        logic tr_step;
        logic succeed;
    } gmb_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic q_empty;
        logic cur_is_end;
        logic nb_in;
        logic nb_free;
        logic dir_last;
        logic t_at_start;
    } gmb_stat_t;

endpackage

// ===== rtl/core/gmb_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmb_ctrl
// sequencer for load and read commands and the clear, search and trace-back phases of a solve
// ----------------------------------------------------------------------------
module gmb_ctrl
    import gmb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] func,
    output logic      busy,
    output gmb_cmd_t  cmd,
    input  gmb_stat_t stat
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_INIT = 4'd2;
    localparam logic [3:0] S_DEQ  = 4'd3;
    localparam logic [3:0] S_CUR  = 4'd4;
    localparam logic [3:0] S_NB   = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_TR   = 4'd7;
    localparam logic [3:0] S_TW   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = (func == FUNC_LOAD);
                    cmd.read = (func == FUNC_READ);
                    if (func == FUNC_SOLVE)
                    begin
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (stat.in_range)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_DEQ;
                end
                else
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEQ:
            begin
                if (stat.q_empty)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.deq    = 1'b1;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cmd.cur    = 1'b1;
                state_next = S_NB;
            end
            S_NB:
            begin
                priority if (stat.cur_is_end)
                begin
                    cmd.tr_begin = 1'b1;
                    state_next   = S_TR;
                end
                else if (stat.nb_in)
                begin
                    cmd.nb_read = 1'b1;
                    state_next  = S_CHK;
                end
                else
                begin
                    cmd.dir_next = 1'b1;
                    state_next   = stat.dir_last ? S_DEQ : S_NB;
                end
            end
            S_CHK:
            begin
                cmd.nb_take  = stat.nb_free;
                cmd.dir_next = 1'b1;
                state_next   = stat.dir_last ? S_DEQ : S_NB;
            end
            S_TR:
            begin
                if (stat.t_at_start)
                begin
                    cmd.succeed = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.tr_read = 1'b1;
                    state_next  = S_TW;
                end
            end
            S_TW:
            begin
                cmd.tr_step = 1'b1;
                state_next  = S_TR;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/gmb_dpath.sv =====
// ----------------------------------------------------------------------------
// gmb_dpath
// maps, queue, path store, configuration and result registers
// ----------------------------------------------------------------------------
module gmb_dpath
    import gmb_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  gmb_in_t   cmd_in,
    input  gmb_cmd_t  cmd,
    output gmb_stat_t stat,
    input  logic      cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data,
    output logic      done,
    output gmb_out_t  rsp
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    // configuration
    logic [6:0] rows_reg, cols_reg;
    logic [5:0] srow_reg, scol_reg, erow_reg, ecol_reg;
    logic [8:0] rows_eff, cols_eff;

    // memories
    logic          wall_mem [DEPTH];
    logic          vis_mem  [DEPTH];
    logic [1:0]    par_mem  [DEPTH];
    logic [AW-1:0] queue_mem[DEPTH];
    logic [1:0]    path_mem [DEPTH];

    logic          wall_q, vis_q;
    logic [1:0]    par_q, pm_q;
    logic [AW-1:0] q_rd;

    logic [AW-1:0] clr_addr_reg;
    logic [AW:0]   head_reg, tail_reg;
    logic [RW-1:0] cur_r_reg, t_r_reg, t_r_next;
    logic [CW-1:0] cur_c_reg, t_c_reg, t_c_next;
    logic [1:0]    dir_reg;
    logic [AW:0]   len_reg, count_reg, rp_reg;
    logic          found_reg;

    logic          done_reg, rd_pend_reg, rd_hit_reg, rd_last_reg;
    gmb_out_t      rsp_reg;

    logic [AW-1:0] s_addr, e_addr, cur_addr, nb_addr, t_addr, ld_addr, rd_addr;
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    logic          nb_in;
    logic          ld_ok, rd_hit;
    logic [AW:0]   rd_idx;

    assign rows_eff = (9'(rows_reg) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(rows_reg);
    assign cols_eff = (9'(cols_reg) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(cols_reg);

    assign s_addr   = {RW'(srow_reg), CW'(scol_reg)};
    assign e_addr   = {RW'(erow_reg), CW'(ecol_reg)};
    assign cur_addr = {cur_r_reg, cur_c_reg};
    assign t_addr   = {t_r_reg, t_c_reg};
    assign ld_addr  = {RW'(cmd_in.cell_row), CW'(cmd_in.cell_col)};
    assign ld_ok    = (9'(cmd_in.cell_row) < 9'(MAX_ROWS))
                   && (9'(cmd_in.cell_col) < 9'(MAX_COLS));

    // neighbour of the current cell in the present direction
    always_comb
    begin
        nb_r  = cur_r_reg;
        nb_c  = cur_c_reg;
        nb_in = 1'b0;
        unique case (dir_reg)
            DIR_DOWN:
            begin
                nb_r  = cur_r_reg + RW'(1);
                nb_in = (9'(cur_r_reg) + 9'd1) < rows_eff;
            end
            DIR_RIGHT:
            begin
                nb_c  = cur_c_reg + CW'(1);
                nb_in = (9'(cur_c_reg) + 9'd1) < cols_eff;
            end
            DIR_LEFT:
            begin
                nb_c  = cur_c_reg - CW'(1);
                nb_in = (cur_c_reg != '0);
            end
            DIR_UP:
            begin
                nb_r  = cur_r_reg - RW'(1);
                nb_in = (cur_r_reg != '0);
            end
            default:
            begin
                nb_in = 1'b0;
            end
        endcase
    end
    assign nb_addr    = {nb_r, nb_c};
    assign stat.nb_in = nb_in;

    // parent step during trace-back
    always_comb
    begin
        t_r_next = t_r_reg;
        t_c_next = t_c_reg;
        unique case (par_q)
            DIR_DOWN:  t_r_next = t_r_reg + RW'(1);
            DIR_RIGHT: t_c_next = t_c_reg + CW'(1);
            DIR_LEFT:  t_c_next = t_c_reg - CW'(1);
            DIR_UP:    t_r_next = t_r_reg - RW'(1);
            default:   t_r_next = t_r_reg;
        endcase
    end

    assign stat.clr_last   = (clr_addr_reg == '1);
    assign stat.in_range   = (9'(srow_reg) < rows_eff) && (9'(scol_reg) < cols_eff)
                          && (9'(erow_reg) < rows_eff) && (9'(ecol_reg) < cols_eff);
    assign stat.q_empty    = (head_reg == tail_reg);
    assign stat.cur_is_end = (cur_addr == e_addr);
    assign stat.nb_free    = !vis_q && !wall_q;
    assign stat.dir_last   = (dir_reg == DIR_UP);
    assign stat.t_at_start = (t_addr == s_addr);

    assign rd_hit  = found_reg && (rp_reg < count_reg);
    assign rd_idx  = count_reg - rp_reg - (AW+1)'(1);
    assign rd_addr = rd_idx[AW-1:0];

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load && ld_ok)
        begin
            wall_mem[ld_addr] <= cmd_in.blocked;
        end
        if (cmd.clr)
        begin
            vis_mem[clr_addr_reg] <= 1'b0;
        end
        else if (cmd.init)
        begin
            vis_mem[s_addr] <= 1'b1;
        end
        else if (cmd.nb_take)
        begin
            vis_mem[nb_addr] <= 1'b1;
        end
        if (cmd.nb_take)
        begin
            par_mem[nb_addr]              <= DIR_UP - dir_reg;
            queue_mem[tail_reg[AW-1:0]]   <= nb_addr;
        end
        else if (cmd.init)
        begin
            queue_mem[0] <= s_addr;
        end
        if (cmd.tr_step)
        begin
            path_mem[len_reg[AW-1:0]] <= par_q;
        end
        wall_q <= wall_mem[nb_addr];
        vis_q  <= vis_mem[nb_addr];
        q_rd   <= queue_mem[head_reg[AW-1:0]];
        par_q  <= par_mem[t_addr];
        pm_q   <= path_mem[rd_addr];
    end

    // search and trace registers
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            head_reg <= '0;
            tail_reg <= (AW+1)'(1);
        end
        else
        begin
            if (cmd.deq)
            begin
                head_reg <= head_reg + (AW+1)'(1);
            end
            if (cmd.nb_take)
            begin
                tail_reg <= tail_reg + (AW+1)'(1);
            end
        end
        if (cmd.cur)
        begin
            cur_r_reg <= q_rd[AW-1:CW];
            cur_c_reg <= q_rd[CW-1:0];
            dir_reg   <= DIR_DOWN;
        end
        else if (cmd.dir_next)
        begin
            dir_reg <= dir_reg + 2'd1;
        end
        if (cmd.tr_begin)
        begin
            t_r_reg <= RW'(erow_reg);
            t_c_reg <= CW'(ecol_reg);
            len_reg <= '0;
        end
        else if (cmd.tr_step)
        begin
            t_r_reg <= t_r_next;
            t_c_reg <= t_c_next;
            len_reg <= len_reg + (AW+1)'(1);
        end
    end

    // configuration, path state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= 7'd64;
            cols_reg     <= 7'd64;
            srow_reg     <= '0;
            scol_reg     <= '0;
            erow_reg     <= '0;
            ecol_reg     <= '0;
            clr_addr_reg <= '0;
            found_reg    <= 1'b0;
            count_reg    <= '0;
            rp_reg       <= '0;
            done_reg     <= 1'b0;
            rd_pend_reg  <= 1'b0;
            rd_hit_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_ROWS:  rows_reg <= cfg_data;
                    CFG_NUM_COLS:  cols_reg <= cfg_data;
                    CFG_START_ROW: srow_reg <= cfg_data[5:0];
                    CFG_START_COL: scol_reg <= cfg_data[5:0];
                    CFG_END_ROW:   erow_reg <= cfg_data[5:0];
                    CFG_END_COL:   ecol_reg <= cfg_data[5:0];
                    default:       rows_reg <= rows_reg;
                endcase
            end
            if (cmd.clr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            done_reg    <= cmd.fail || cmd.succeed;
            rd_pend_reg <= cmd.read;
            rd_hit_reg  <= cmd.read && rd_hit;
            rd_last_reg <= cmd.read && rd_hit && (rp_reg + (AW+1)'(1) == count_reg);
            if (cmd.read && rd_hit)
            begin
                rp_reg <= rp_reg + (AW+1)'(1);
            end
            if (cmd.fail)
            begin
                found_reg <= 1'b0;
                count_reg <= '0;
                rp_reg    <= '0;
                rsp_reg   <= '0;
            end
            else if (cmd.succeed)
            begin
                found_reg <= 1'b1;
                count_reg <= len_reg;
                rp_reg    <= '0;
                rsp_reg   <= '{found:       1'b1,
                               path_length: (32'(len_reg) > 32'(LEN_MAX)) ? LEN_MAX
                                                                          : 12'(len_reg),
                               move_valid:  1'b0,
                               move:        2'd0,
                               last_move:   1'b0};
            end
        end
    end

    assign done = done_reg || rd_pend_reg;

    always_comb
    begin
        if (rd_pend_reg)
        begin
            rsp            = '0;
            rsp.move_valid = rd_hit_reg;
            rsp.move       = rd_hit_reg ? pm_q : 2'd0;
            rsp.last_move  = rd_last_reg;
        end
        else
        begin
            rsp = rsp_reg;
        end
    end

endmodule

// ===== rtl/core/grid_maze_bfs_path.sv =====
// ----------------------------------------------------------------------------
// grid_maze_bfs_path
// breadth-first shortest path search over a loaded grid, with path read-out
//
// channel   ports                          beat
// command   start, busy, cmd               start & !busy
// result    done, rsp                      done (one cycle, no hold-off)
// config    cfg_we, cfg_index, cfg_data    cfg_we
//
// load: no result. read: result on the next cycle.
// solve: a sweep that clears the visited map, then an init step, then a search that
// dequeues each cell and checks each of its neighbours, then a trace-back per move.
// busy stays high for the whole solve; solve result strobes as busy falls.
// sequencer, configuration and result state clear on rst_n; maps and search registers hold no reset value.
// ----------------------------------------------------------------------------
module grid_maze_bfs_path
    import gmb_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  gmb_in_t    cmd,
    output logic       done,
    output gmb_out_t   rsp,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data
);

    gmb_cmd_t  ctl;
    gmb_stat_t stat;

    gmb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (cmd.func),
        .busy  (busy),
        .cmd   (ctl),
        .stat  (stat)
    );

    gmb_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd),
        .cmd       (ctl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/core/gmb_chk.sv =====
// ----------------------------------------------------------------------------
// gmb_chk
// port-level checks for the grid maze path search block
// ----------------------------------------------------------------------------
module gmb_chk
    import gmb_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input gmb_in_t  cmd,
    input logic     done,
    input gmb_out_t rsp
);

    a_read_beat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == FUNC_READ |=> done)
        else $error("read beat gave no result");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == FUNC_LOAD |=> !done)
        else $error("load beat gave a result");

    a_move_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.move_valid |-> !rsp.found && rsp.path_length == '0)
        else $error("read result mixed with solve fields");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.last_move |-> rsp.move_valid)
        else $error("last move without a move");

endmodule

bind grid_maze_bfs_path gmb_chk u_gmb_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
);
